[src/gcdl_pkg.sv]
package gcdl_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int CountWidth    = $clog2(OPERAND_WIDTH);
  localparam int InWidth       = 32;
  localparam int GcdOutWidth   = 32;
  localparam int LcmOutWidth   = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } gcdl_state_t;

endpackage

[src/gcdl_in_if.sv]
interface gcdl_in_if;
  logic                          valid;
  logic                          ready;
  logic [gcdl_pkg::InWidth-1:0]  first_operand;
  logic [gcdl_pkg::InWidth-1:0]  second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink (input valid, input first_operand, input second_operand, output ready);
endinterface

[src/gcdl_out_if.sv]
interface gcdl_out_if;
  logic                             valid;
  logic                             ready;
  logic [gcdl_pkg::GcdOutWidth-1:0] divisor_result;
  logic [gcdl_pkg::LcmOutWidth-1:0] multiple_result;
  logic                             zero_operand_error;

  modport source (output valid, output divisor_result, output multiple_result,
                  output zero_operand_error, input ready);
  modport sink (input valid, input divisor_result, input multiple_result,
                input zero_operand_error, output ready);
endinterface

[src/gcdl_sub.sv]
module gcdl_sub (
  input  logic [gcdl_pkg::OPERAND_WIDTH:0] x,
  input  logic [gcdl_pkg::OPERAND_WIDTH:0] y,
  output logic [gcdl_pkg::OPERAND_WIDTH:0] diff,
  output logic                             borrow
);
  logic [gcdl_pkg::OPERAND_WIDTH+1:0] wide;

  assign wide   = {1'b0, x} - {1'b0, y};
  assign diff   = wide[gcdl_pkg::OPERAND_WIDTH:0];
  assign borrow = wide[gcdl_pkg::OPERAND_WIDTH+1];
endmodule

[src/gcdl_mul.sv]
module gcdl_mul (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic [gcdl_pkg::OPERAND_WIDTH-1:0]   a,
  input  logic [gcdl_pkg::OPERAND_WIDTH-1:0]   b,
  output logic [2*gcdl_pkg::OPERAND_WIDTH-1:0] p
);
  always_ff @(posedge clk) begin
    if (load) begin
      p <= {{gcdl_pkg::OPERAND_WIDTH{1'b0}}, a} * {{gcdl_pkg::OPERAND_WIDTH{1'b0}}, b};
    end
  end
endmodule

[src/gcd_and_lcm.sv]
// Greatest common divisor and least common multiple of two unsigned operands, masked to
// OPERAND_WIDTH bits. One item at a time: operands.ready is high only while idle. The gcd
// comes from a binary shift/subtract loop, then first/gcd runs as a restoring division on
// the same subtractor, then a registered multiply by the second operand; the result is
// then offered in ST_DONE. A zero operand gives zero_operand_error with both results 0
// on the cycle after acceptance.
module gcd_and_lcm (
  input  logic       clk,
  input  logic       rst,
  gcdl_in_if.sink    operands,
  gcdl_out_if.source results
);
  localparam int W = gcdl_pkg::OPERAND_WIDTH;

  gcdl_pkg::gcdl_state_t state, state_next;

  logic [W-1:0] op_a, op_b;
  logic [W-1:0] x, y, g, quot, rem;
  logic [gcdl_pkg::CountWidth-1:0] k, cnt;
  logic         err;

  logic [W:0]   sub_x, sub_y, diff;
  logic         borrow;
  logic [2*W-1:0] prod;
  logic         gcd_done, div_last;
  logic [W-1:0] a_in, b_in;

  assign a_in = operands.first_operand[W-1:0];
  assign b_in = operands.second_operand[W-1:0];

  always_comb begin
    if (state == gcdl_pkg::ST_DIV) begin
      sub_x = {rem, quot[W-1]};
      sub_y = {1'b0, g};
    end else begin
      sub_x = {1'b0, x};
      sub_y = {1'b0, y};
    end
  end

  gcdl_sub u_sub (
    .x      (sub_x),
    .y      (sub_y),
    .diff   (diff),
    .borrow (borrow)
  );

  gcdl_mul u_mul (
    .clk  (clk),
    .load (state == gcdl_pkg::ST_MUL),
    .a    (quot),
    .b    (op_b),
    .p    (prod)
  );

  assign gcd_done = !borrow && (diff == '0);
  assign div_last = (cnt == gcdl_pkg::CountWidth'(W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcdl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gcdl_pkg::ST_IDLE: begin
        if (operands.valid) begin
          if (a_in == '0 || b_in == '0) begin
            state_next = gcdl_pkg::ST_DONE;
          end else begin
            state_next = gcdl_pkg::ST_GCD;
          end
        end
      end
      gcdl_pkg::ST_GCD: begin
        if (gcd_done) begin
          state_next = gcdl_pkg::ST_DIV;
        end
      end
      gcdl_pkg::ST_DIV: begin
        if (div_last) begin
          state_next = gcdl_pkg::ST_MUL;
        end
      end
      gcdl_pkg::ST_MUL: state_next = gcdl_pkg::ST_DONE;
      gcdl_pkg::ST_DONE: begin
        if (results.ready) begin
          state_next = gcdl_pkg::ST_IDLE;
        end
      end
      default: state_next = gcdl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      gcdl_pkg::ST_IDLE: begin
        if (operands.valid) begin
          op_a <= a_in;
          op_b <= b_in;
          x    <= a_in;
          y    <= b_in;
          k    <= '0;
          err  <= (a_in == '0 || b_in == '0);
        end
      end
      gcdl_pkg::ST_GCD: begin
        if (gcd_done) begin
          g    <= x << k;
          rem  <= '0;
          quot <= op_a;
          cnt  <= '0;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (borrow) begin
          x <= y;
          y <= x;
        end else begin
          x <= diff[W:1];
        end
      end
      gcdl_pkg::ST_DIV: begin
        quot <= {quot[W-2:0], !borrow};
        rem  <= borrow ? sub_x[W-1:0] : diff[W-1:0];
        cnt  <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign operands.ready             = (state == gcdl_pkg::ST_IDLE);
  assign results.valid              = (state == gcdl_pkg::ST_DONE);
  assign results.zero_operand_error = err;
  assign results.divisor_result     = err ? '0 : gcdl_pkg::GcdOutWidth'(g);
  assign results.multiple_result    = err ? '0 : gcdl_pkg::LcmOutWidth'(prod);

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !operands.ready)
    else $error("input taken while a result is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> !operands.ready)
    else $error("ready still high after accept");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.zero_operand_error |->
      results.divisor_result == '0 && results.multiple_result == '0)
    else $error("error result carries nonzero fields");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.zero_operand_error |-> results.divisor_result != '0)
    else $error("zero gcd without error");

  a_div_by_g: assert property (@(posedge clk) disable iff (rst)
    state == gcdl_pkg::ST_DIV |-> g != '0)
    else $error("division by zero gcd");
endmodule
